// ===== rtl/hdp_pkg.sv =====
// Shared types, constants and tables of the HTTP date parser.
`default_nettype none

package hdp_pkg;

    // One byte of the date string.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_item;

    // One parse result.
    typedef struct packed {
        logic        date_valid;
        logic [31:0] unix_seconds;
    } t_result;

    // Position within the date layouts.
    typedef enum logic [4:0] {
        PH_TOKEN  = 5'd0,
        PH_SKIP   = 5'd1,
        PH_DAY    = 5'd2,
        PH_DAYSEP = 5'd3,
        PH_MON1   = 5'd4,
        PH_MON2   = 5'd5,
        PH_MON3   = 5'd6,
        PH_MONSEP = 5'd7,
        PH_YEAR4  = 5'd8,
        PH_YEAR2  = 5'd9,
        PH_ISOOPT = 5'd10,
        PH_ISOD1  = 5'd11,
        PH_ISOD2  = 5'd12,
        PH_SP     = 5'd13,
        PH_HOUR   = 5'd14,
        PH_COLON1 = 5'd15,
        PH_MIN    = 5'd16,
        PH_COLON2 = 5'd17,
        PH_SEC    = 5'd18,
        PH_SP2    = 5'd19,
        PH_DONE   = 5'd20
    } t_phase;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_822  = 2'd1,
        FMT_850  = 2'd2,
        FMT_ASC  = 2'd3
    } t_fmt;

    // Month numbers, January first.
    localparam logic [3:0] M_JAN = 4'd0;
    localparam logic [3:0] M_FEB = 4'd1;
    localparam logic [3:0] M_MAR = 4'd2;
    localparam logic [3:0] M_APR = 4'd3;
    localparam logic [3:0] M_MAY = 4'd4;
    localparam logic [3:0] M_JUN = 4'd5;
    localparam logic [3:0] M_JUL = 4'd6;
    localparam logic [3:0] M_AUG = 4'd7;
    localparam logic [3:0] M_SEP = 4'd8;
    localparam logic [3:0] M_OCT = 4'd9;
    localparam logic [3:0] M_NOV = 4'd10;
    localparam logic [3:0] M_DEC = 4'd11;
    localparam logic [3:0] MONTHS = 4'd12;

    localparam int YEAR_WIDTH = 14;
    localparam int FIELD_WIDTH = 7;

    // Parsed fields of one complete string, handed to the arithmetic pipeline.
    typedef struct packed {
        logic                   ok;
        logic [YEAR_WIDTH-1:0]  year;
        logic [3:0]             month;
        logic [FIELD_WIDTH-1:0] day;
        logic [FIELD_WIDTH-1:0] hour;
        logic [FIELD_WIDTH-1:0] minute;
        logic [FIELD_WIDTH-1:0] second;
    } t_snap;

    // Day count of the year that precedes year zero, taken modulo 2^32.
    localparam logic [63:0] WRAP_YEAR = 64'hFFFF_FFFF;
    localparam logic [31:0] WRAP_DAYS =
        32'(64'd365 * WRAP_YEAR + WRAP_YEAR / 64'd4 - WRAP_YEAR / 64'd100
            + WRAP_YEAR / 64'd400);

    // Offset that turns the March-based day count into days since 1970.
    localparam logic [31:0] DAY_EPOCH = 32'(719527 + 30 + 1 - 31 - 28);

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // Reciprocal of 100 for values below 2^14: q = (y * 5243) >> 19.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        unique case (m)
            M_JAN, M_MAR, M_MAY, M_JUL, M_AUG, M_OCT, M_DEC: d = 5'd31;
            M_APR, M_JUN, M_SEP, M_NOV:                      d = 5'd30;
            M_FEB:                                           d = 5'd28;
            default:                                         d = 5'd0;
        endcase
        return d;
    endfunction

    // (367 * mm) / 12 where mm counts months from March (January is 11).
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] o;
        unique case (m)
            M_JAN:   o = 9'd336;
            M_FEB:   o = 9'd367;
            M_MAR:   o = 9'd30;
            M_APR:   o = 9'd61;
            M_MAY:   o = 9'd91;
            M_JUN:   o = 9'd122;
            M_JUL:   o = 9'd152;
            M_AUG:   o = 9'd183;
            M_SEP:   o = 9'd214;
            M_OCT:   o = 9'd244;
            M_NOV:   o = 9'd275;
            M_DEC:   o = 9'd305;
            default: o = 9'd0;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/http_date_parser.sv =====
// Top level of the HTTP date parser: byte parser followed by the seconds pipeline.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_in_item  (char_byte, last_byte)
//   out      source     o_out_valid / i_out_stall  o_out_item (date_valid, unix_seconds)
//
// One byte is taken per cycle unless the input stalls; every byte updates the parser
// fields, and the last byte of a string also loads the hand-off register. Its result
// reaches the output register via the hand-off register and three arithmetic stages.
// Reset is synchronous and active low and returns the parser to the weekday token.
// A stalled output holds its result; bytes keep flowing until the pipeline is full.
`default_nettype none

module http_date_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  hdp_pkg::t_item     i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output hdp_pkg::t_result   o_out_item
);

    logic           snap_valid;
    logic           snap_ready;
    hdp_pkg::t_snap snap;

    hdp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_item       (i_in_item),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    hdp_calc u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_result     (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/hdp_parser.sv =====
// Byte-at-a-time field parser of the date string, with the hand-off register.
`default_nettype none

module hdp_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  hdp_pkg::t_item     i_item,
    output logic               o_snap_valid,
    input  wire logic          i_snap_ready,
    output hdp_pkg::t_snap     o_snap
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UJ    = 8'h4A;
    localparam logic [7:0] CH_UM    = 8'h4D;
    localparam logic [7:0] CH_UN    = 8'h4E;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_US    = 8'h53;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LR    = 8'h72;

    localparam int YW = hdp_pkg::YEAR_WIDTH;
    localparam int FW = hdp_pkg::FIELD_WIDTH;

    // Accumulate one decimal digit; a count of zero starts a new number.
    function automatic logic [YW-1:0] acc_step(input logic [YW-1:0] acc,
                                               input logic [2:0] cnt,
                                               input logic [3:0] dv);
        logic [YW+3:0] sum;
        sum = ((cnt == 3'd0) ? '0 : {4'd0, acc}) * (YW+4)'(10) + (YW+4)'(dv);
        return sum[YW-1:0];
    endfunction

    hdp_pkg::t_phase r_phase, n_phase;
    hdp_pkg::t_fmt   r_fmt, n_fmt;
    logic [2:0]      r_dcnt, n_dcnt;
    logic            r_err, n_err;
    logic [FW-1:0]   r_day, n_day;
    logic [7:0]      r_mlo, n_mlo;
    logic [7:0]      r_mhi, n_mhi;
    logic [3:0]      r_mon, n_mon;
    logic [YW-1:0]   r_year, n_year;
    logic [FW-1:0]   r_hour, n_hour;
    logic [FW-1:0]   r_min, n_min;
    logic [FW-1:0]   r_sec, n_sec;

    logic            r_snap_v;
    hdp_pkg::t_snap  r_snap;

    logic [7:0]      c;
    logic            c_dig;
    logic [3:0]      dv;
    logic [2:0]      cnt_inc;
    logic            two_done;
    logic            four_done;
    logic [YW-1:0]   acc_v;
    logic            take;
    logic            take_last;

    assign c         = i_item.char_byte;
    assign c_dig     = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dv        = c[3:0];
    assign cnt_inc   = r_dcnt + 3'd1;
    assign two_done  = cnt_inc >= 3'd2;
    assign four_done = cnt_inc >= 3'd4;

    assign o_stall   = r_snap_v && !i_snap_ready;
    assign take      = i_valid && !o_stall;
    assign take_last = take && i_item.last_byte;

    always_comb begin
        n_phase = r_phase;
        n_fmt   = r_fmt;
        n_dcnt  = r_dcnt;
        n_err   = r_err;
        n_day   = r_day;
        n_mlo   = r_mlo;
        n_mhi   = r_mhi;
        n_mon   = r_mon;
        n_year  = r_year;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        acc_v   = '0;

        unique case (r_phase)
            hdp_pkg::PH_TOKEN: begin
                if (c == CH_COMMA) begin
                    n_phase = hdp_pkg::PH_SKIP;
                end else if (c == CH_SPACE) begin
                    n_fmt   = hdp_pkg::FMT_ASC;
                    n_phase = hdp_pkg::PH_SKIP;
                end
            end
            hdp_pkg::PH_SKIP, hdp_pkg::PH_MON1: begin
                if (r_phase == hdp_pkg::PH_MON1 ||
                        (c != CH_SPACE && r_fmt == hdp_pkg::FMT_ASC)) begin
                    // First month letter.
                    n_mlo = c;
                    n_mhi = '0;
                    if (c == CH_UJ || c == CH_UF || c == CH_UM || c == CH_UA ||
                            c == CH_US || c == CH_UO || c == CH_UN || c == CH_UD) begin
                        n_phase = hdp_pkg::PH_MON2;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = hdp_pkg::PH_DONE;
                    end
                end else if (c != CH_SPACE) begin
                    if (!c_dig) begin
                        n_err   = 1'b1;
                        n_phase = hdp_pkg::PH_DONE;
                    end else begin
                        n_day   = FW'(dv);
                        n_dcnt  = 3'd1;
                        n_phase = hdp_pkg::PH_DAY;
                    end
                end
            end
            hdp_pkg::PH_DAY: begin
                acc_v = acc_step(YW'(r_day), r_dcnt, dv);
                if (!c_dig) begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end else begin
                    n_day = acc_v[FW-1:0];
                    if (two_done) begin
                        n_dcnt  = '0;
                        n_phase = hdp_pkg::PH_DAYSEP;
                    end else begin
                        n_dcnt = cnt_inc;
                    end
                end
            end
            hdp_pkg::PH_DAYSEP: begin
                if (c == CH_SPACE) begin
                    n_fmt   = hdp_pkg::FMT_822;
                    n_phase = hdp_pkg::PH_MON1;
                end else if (c == CH_DASH) begin
                    n_fmt   = hdp_pkg::FMT_850;
                    n_phase = hdp_pkg::PH_MON1;
                end else begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end
            end
            hdp_pkg::PH_MON2: begin
                n_mhi   = c;
                n_phase = hdp_pkg::PH_MON3;
            end
            hdp_pkg::PH_MON3: begin
                // Loose match: only the letters that tell months apart are used.
                unique case (r_mlo)
                    CH_UJ: begin
                        if (r_mhi == CH_LA) begin
                            n_mon = hdp_pkg::M_JAN;
                        end else if (c == CH_LN) begin
                            n_mon = hdp_pkg::M_JUN;
                        end else begin
                            n_mon = hdp_pkg::M_JUL;
                        end
                    end
                    CH_UF:   n_mon = hdp_pkg::M_FEB;
                    CH_UM:   n_mon = (c == CH_LR) ? hdp_pkg::M_MAR : hdp_pkg::M_MAY;
                    CH_UA:   n_mon = (r_mhi == CH_LP) ? hdp_pkg::M_APR : hdp_pkg::M_AUG;
                    CH_US:   n_mon = hdp_pkg::M_SEP;
                    CH_UO:   n_mon = hdp_pkg::M_OCT;
                    CH_UN:   n_mon = hdp_pkg::M_NOV;
                    default: n_mon = hdp_pkg::M_DEC;
                endcase
                n_phase = hdp_pkg::PH_MONSEP;
            end
            hdp_pkg::PH_MONSEP: begin
                if (r_fmt == hdp_pkg::FMT_822) begin
                    if (c != CH_SPACE) begin
                        n_err   = 1'b1;
                        n_phase = hdp_pkg::PH_DONE;
                    end else begin
                        n_phase = hdp_pkg::PH_YEAR4;
                        n_dcnt  = '0;
                    end
                end else if (r_fmt == hdp_pkg::FMT_850) begin
                    if (c != CH_DASH) begin
                        n_err   = 1'b1;
                        n_phase = hdp_pkg::PH_DONE;
                    end else begin
                        n_phase = hdp_pkg::PH_YEAR2;
                        n_dcnt  = '0;
                    end
                end else begin
                    // The byte after an asctime month is not checked.
                    n_phase = hdp_pkg::PH_ISOOPT;
                    n_dcnt  = '0;
                end
            end
            hdp_pkg::PH_YEAR4: begin
                acc_v = acc_step(r_year, r_dcnt, dv);
                if (!c_dig) begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end else begin
                    n_year = acc_v;
                    if (four_done) begin
                        n_dcnt  = '0;
                        n_phase = (r_fmt == hdp_pkg::FMT_ASC) ? hdp_pkg::PH_DONE
                                                              : hdp_pkg::PH_SP;
                    end else begin
                        n_dcnt = cnt_inc;
                    end
                end
            end
            hdp_pkg::PH_YEAR2: begin
                acc_v = acc_step(r_year, r_dcnt, dv);
                if (!c_dig) begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end else if (two_done) begin
                    // Two-digit years below 70 fall in the 2000s.
                    n_year  = acc_v + ((acc_v < YW'(70)) ? YW'(2000) : YW'(1900));
                    n_dcnt  = '0;
                    n_phase = hdp_pkg::PH_SP;
                end else begin
                    n_year = acc_v;
                    n_dcnt = cnt_inc;
                end
            end
            hdp_pkg::PH_ISOOPT, hdp_pkg::PH_ISOD1: begin
                if (r_phase == hdp_pkg::PH_ISOOPT && c == CH_SPACE) begin
                    n_phase = hdp_pkg::PH_ISOD1;
                end else if (!c_dig) begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end else begin
                    n_day   = FW'(dv);
                    n_phase = hdp_pkg::PH_ISOD2;
                end
            end
            hdp_pkg::PH_ISOD2: begin
                acc_v = acc_step(YW'(r_day), 3'd1, dv);
                if (c == CH_SPACE) begin
                    n_phase = hdp_pkg::PH_HOUR;
                    n_dcnt  = '0;
                end else if (c_dig) begin
                    n_day   = acc_v[FW-1:0];
                    n_phase = hdp_pkg::PH_SP;
                end else begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end
            end
            hdp_pkg::PH_SP, hdp_pkg::PH_SP2: begin
                if (c != CH_SPACE) begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end else begin
                    n_phase = (r_phase == hdp_pkg::PH_SP) ? hdp_pkg::PH_HOUR
                                                          : hdp_pkg::PH_YEAR4;
                    n_dcnt  = '0;
                end
            end
            hdp_pkg::PH_HOUR, hdp_pkg::PH_MIN, hdp_pkg::PH_SEC: begin
                if (r_phase == hdp_pkg::PH_HOUR) begin
                    acc_v = acc_step(YW'(r_hour), r_dcnt, dv);
                end else if (r_phase == hdp_pkg::PH_MIN) begin
                    acc_v = acc_step(YW'(r_min), r_dcnt, dv);
                end else begin
                    acc_v = acc_step(YW'(r_sec), r_dcnt, dv);
                end
                if (!c_dig) begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end else begin
                    if (r_phase == hdp_pkg::PH_HOUR) begin
                        n_hour = acc_v[FW-1:0];
                    end else if (r_phase == hdp_pkg::PH_MIN) begin
                        n_min = acc_v[FW-1:0];
                    end else begin
                        n_sec = acc_v[FW-1:0];
                    end
                    if (two_done) begin
                        n_dcnt = '0;
                        if (r_phase == hdp_pkg::PH_HOUR) begin
                            n_phase = hdp_pkg::PH_COLON1;
                        end else if (r_phase == hdp_pkg::PH_MIN) begin
                            n_phase = hdp_pkg::PH_COLON2;
                        end else begin
                            n_phase = (r_fmt == hdp_pkg::FMT_ASC) ? hdp_pkg::PH_SP2
                                                                  : hdp_pkg::PH_DONE;
                        end
                    end else begin
                        n_dcnt = cnt_inc;
                    end
                end
            end
            hdp_pkg::PH_COLON1, hdp_pkg::PH_COLON2: begin
                if (c != CH_COLON) begin
                    n_err   = 1'b1;
                    n_phase = hdp_pkg::PH_DONE;
                end else begin
                    n_phase = (r_phase == hdp_pkg::PH_COLON1) ? hdp_pkg::PH_MIN
                                                              : hdp_pkg::PH_SEC;
                end
            end
            hdp_pkg::PH_DONE: begin
                // Trailing bytes and bytes after an error are ignored.
            end
            default: begin
            end
        endcase
    end

    // Control state; the last byte of a string returns it to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hdp_pkg::PH_TOKEN;
            r_fmt   <= hdp_pkg::FMT_NONE;
            r_dcnt  <= '0;
            r_err   <= 1'b0;
        end else if (take_last) begin
            r_phase <= hdp_pkg::PH_TOKEN;
            r_fmt   <= hdp_pkg::FMT_NONE;
            r_dcnt  <= '0;
            r_err   <= 1'b0;
        end else if (take) begin
            r_phase <= n_phase;
            r_fmt   <= n_fmt;
            r_dcnt  <= n_dcnt;
            r_err   <= n_err;
        end
    end

    // Field values are always written before they are read within a string.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_day  <= n_day;
            r_mlo  <= n_mlo;
            r_mhi  <= n_mhi;
            r_mon  <= n_mon;
            r_year <= n_year;
            r_hour <= n_hour;
            r_min  <= n_min;
            r_sec  <= n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_v <= 1'b0;
        end else if (take_last) begin
            r_snap_v <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_last) begin
            r_snap.ok     <= (n_phase == hdp_pkg::PH_DONE) && !n_err;
            r_snap.year   <= n_year;
            r_snap.month  <= n_mon;
            r_snap.day    <= n_day;
            r_snap.hour   <= n_hour;
            r_snap.minute <= n_min;
            r_snap.second <= n_sec;
        end
    end

    assign o_snap_valid = r_snap_v;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

// ===== rtl/hdp_calc.sv =====
// Range checks and the seconds arithmetic, pipelined over four registered stages.
`default_nettype none

module hdp_calc (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_snap_valid,
    output logic               o_snap_ready,
    input  hdp_pkg::t_snap     i_snap,
    output logic               o_valid,
    input  wire logic          i_stall,
    output hdp_pkg::t_result   o_result
);

    localparam int YW = hdp_pkg::YEAR_WIDTH;
    localparam int FW = hdp_pkg::FIELD_WIDTH;
    localparam int PW = YW + 13;

    // Each stage moves on when it is empty or the stage after it moves on.
    logic rdy1, rdy2, rdy3, rdy4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign rdy4         = !r_v4 || !i_stall;
    assign rdy3         = !r_v3 || rdy4;
    assign rdy2         = !r_v2 || rdy3;
    assign rdy1         = !r_v1 || rdy2;
    assign o_snap_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_snap_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: field checks, March-based year and the divisions by 100.
    logic          feb29;
    logic          early;
    logic [YW-1:0] yp;
    logic [PW-1:0] py;
    logic [PW-1:0] pyp;
    logic          ok1;

    assign feb29 = (i_snap.day == FW'(29)) && (i_snap.month == hdp_pkg::M_FEB);
    assign early = (i_snap.month == hdp_pkg::M_JAN) || (i_snap.month == hdp_pkg::M_FEB);
    assign yp    = early ? i_snap.year - YW'(1) : i_snap.year;
    assign py    = PW'(i_snap.year) * PW'(hdp_pkg::RECIP_100);
    assign pyp   = PW'(yp) * PW'(hdp_pkg::RECIP_100);
    assign ok1   = i_snap.ok && (i_snap.hour <= FW'(23)) && (i_snap.minute <= FW'(59))
                   && (i_snap.second <= FW'(59)) && (i_snap.month < hdp_pkg::MONTHS)
                   && (feb29 || (i_snap.day <= FW'(hdp_pkg::month_days(i_snap.month))));

    logic          r1_ok;
    logic          r1_feb29;
    logic          r1_wrap;
    logic [YW-1:0] r1_year;
    logic [6:0]    r1_q100y;
    logic [YW-1:0] r1_yp;
    logic [6:0]    r1_q100yp;
    logic [8:0]    r1_moff;
    logic [FW-1:0] r1_day, r1_hour, r1_min, r1_sec;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_ok     <= ok1;
            r1_feb29  <= feb29;
            // Year zero before March steps back to the year 2^32 - 1.
            r1_wrap   <= early && (i_snap.year == '0);
            r1_year   <= i_snap.year;
            r1_q100y  <= py[hdp_pkg::RECIP_SHIFT+6:hdp_pkg::RECIP_SHIFT];
            r1_yp     <= yp;
            r1_q100yp <= pyp[hdp_pkg::RECIP_SHIFT+6:hdp_pkg::RECIP_SHIFT];
            r1_moff   <= hdp_pkg::month_offset(i_snap.month);
            r1_day    <= i_snap.day;
            r1_hour   <= i_snap.hour;
            r1_min    <= i_snap.minute;
            r1_sec    <= i_snap.second;
        end
    end

    // Stage 2: leap-year rule and the day count.
    logic          r100_zero;
    logic          leap_bad;
    logic [31:0]   base_days;
    logic [31:0]   days;

    assign r100_zero = r1_year == (YW'(r1_q100y) * YW'(100));
    assign leap_bad  = (r1_year[1:0] != 2'd0) || (r100_zero && (r1_q100y[1:0] != 2'd0));
    assign base_days = 32'(r1_yp) * 32'd365 + 32'(r1_yp[YW-1:2]) - 32'(r1_q100yp)
                       + 32'(r1_q100yp[6:2]);
    assign days      = (r1_wrap ? hdp_pkg::WRAP_DAYS : base_days) + 32'(r1_moff)
                       + 32'(r1_day) - hdp_pkg::DAY_EPOCH;

    logic          r2_ok;
    logic [31:0]   r2_days;
    logic [FW-1:0] r2_hour, r2_min, r2_sec;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ok   <= r1_ok && !(r1_feb29 && leap_bad);
            r2_days <= days;
            r2_hour <= r1_hour;
            r2_min  <= r1_min;
            r2_sec  <= r1_sec;
        end
    end

    // Stage 3: days to seconds, plus the time of day.
    logic          r3_ok;
    logic [31:0]   r3_prod;
    logic [18:0]   r3_tod;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_ok   <= r2_ok;
            r3_prod <= r2_days * 32'(hdp_pkg::SECS_PER_DAY);
            r3_tod  <= 19'(r2_hour) * 19'(hdp_pkg::SECS_PER_HOUR)
                       + 19'(r2_min) * 19'(hdp_pkg::SECS_PER_MIN) + 19'(r2_sec);
        end
    end

    // Stage 4: output register, holding the sum of the two parts or zero for an invalid date.
    hdp_pkg::t_result r4_res;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_res.date_valid   <= r3_ok;
            r4_res.unix_seconds <= r3_ok ? (r3_prod + 32'(r3_tod)) : 32'd0;
        end
    end

    assign o_valid  = r_v4;
    assign o_result = r4_res;

endmodule

`default_nettype wire

// ===== test/http_date_parser_tb.sv =====
// Self-checking testbench for the HTTP date parser: directed and random date strings.
`timescale 1ns / 100ps

module http_date_parser_tb;
    import hdp_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        t_item item;
        logic  drain_first;
    } t_feed_byte;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    t_item   in_item = '0;
    logic    in_stall;
    logic    out_valid;
    logic    out_stall = 1'b0;
    t_result out_item;

    t_feed_byte  byte_feed[$];
    t_result     expected_dates[$];
    logic [7:0]  str_bytes[$];

    int unsigned cycle_no = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_started = 1'b0;
    int unsigned bytes_taken = 0;
    int unsigned in_stalls = 0;
    int unsigned strings_done = 0;
    int unsigned strings_valid = 0;
    int unsigned results_checked = 0;
    int unsigned errors = 0;

    // Parser state of the prediction.
    t_phase      dp_phase = PH_TOKEN;
    t_fmt        dp_fmt = FMT_NONE;
    logic [15:0] dp_letters = '0;
    logic [3:0]  dp_month = M_JAN;
    int unsigned dp_day, dp_year, dp_hour, dp_minute, dp_second, dp_count;
    bit          dp_error;

    int unsigned days_in_month[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    http_date_parser DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void parser_clear();
        dp_phase = PH_TOKEN;
        dp_fmt = FMT_NONE;
        dp_letters = '0;
        dp_month = M_JAN;
        dp_day = 0;
        dp_year = 0;
        dp_hour = 0;
        dp_minute = 0;
        dp_second = 0;
        dp_count = 0;
        dp_error = 1'b0;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void parse_error();
        dp_error = 1'b1;
        dp_phase = PH_DONE;
    endfunction

    // Takes one digit of a fixed-length number and tells when the number is complete.
    function automatic bit take_digit(input logic [7:0] c, inout int unsigned acc,
                                      input int unsigned len);
        if (!is_digit(c)) begin
            parse_error();
            return 1'b0;
        end
        if (dp_count == 0) acc = 0;
        acc = acc * 10 + 32'(c - CH_ZERO);
        dp_count++;
        if (dp_count >= len) begin
            dp_count = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void month_lead(input logic [7:0] c);
        dp_letters = {8'h00, c};
        case (c)
            "J", "F", "M", "A", "S", "O", "N", "D": dp_phase = PH_MON2;
            default: parse_error();
        endcase
    endfunction

    // Only the letters needed to tell the months apart are looked at.
    function automatic void month_close(input logic [7:0] c);
        logic [7:0] b;
        b = dp_letters[15:8];
        case (dp_letters[7:0])
            "J":     dp_month = (b == "a") ? M_JAN : (c == "n") ? M_JUN : M_JUL;
            "F":     dp_month = M_FEB;
            "M":     dp_month = (c == "r") ? M_MAR : M_MAY;
            "A":     dp_month = (b == "p") ? M_APR : M_AUG;
            "S":     dp_month = M_SEP;
            "O":     dp_month = M_OCT;
            "N":     dp_month = M_NOV;
            default: dp_month = M_DEC;
        endcase
        dp_phase = PH_MONSEP;
    endfunction

    function automatic void asc_day_lead(input logic [7:0] c);
        if (!is_digit(c)) begin
            parse_error();
        end else begin
            dp_day = 32'(c - CH_ZERO);
            dp_phase = PH_ISOD2;
        end
    endfunction

    function automatic void feed_byte(input logic [7:0] c);
        case (dp_phase)
            PH_TOKEN: begin
                if (c == CH_COMMA) begin
                    dp_phase = PH_SKIP;
                end else if (c == CH_SPACE) begin
                    dp_fmt = FMT_ASC;
                    dp_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (c != CH_SPACE) begin
                    if (dp_fmt == FMT_ASC) begin
                        month_lead(c);
                    end else begin
                        dp_phase = PH_DAY;
                        dp_count = 0;
                        if (take_digit(c, dp_day, 2)) dp_phase = PH_DAYSEP;
                    end
                end
            end
            PH_DAY: if (take_digit(c, dp_day, 2)) dp_phase = PH_DAYSEP;
            PH_DAYSEP: begin
                if (c == CH_SPACE) begin
                    dp_fmt = FMT_822;
                    dp_phase = PH_MON1;
                end else if (c == CH_DASH) begin
                    dp_fmt = FMT_850;
                    dp_phase = PH_MON1;
                end else begin
                    parse_error();
                end
            end
            PH_MON1: month_lead(c);
            PH_MON2: begin
                dp_letters[15:8] = c;
                dp_phase = PH_MON3;
            end
            PH_MON3: month_close(c);
            PH_MONSEP: begin
                if (dp_fmt == FMT_822 && c != CH_SPACE) begin
                    parse_error();
                end else if (dp_fmt == FMT_850 && c != CH_DASH) begin
                    parse_error();
                end else begin
                    // The asctime layout does not look at this byte.
                    dp_phase = (dp_fmt == FMT_822) ? PH_YEAR4 :
                               (dp_fmt == FMT_850) ? PH_YEAR2 : PH_ISOOPT;
                    dp_count = 0;
                end
            end
            PH_YEAR4: begin
                if (take_digit(c, dp_year, 4))
                    dp_phase = (dp_fmt == FMT_ASC) ? PH_DONE : PH_SP;
            end
            PH_YEAR2: begin
                if (take_digit(c, dp_year, 2)) begin
                    dp_year += (dp_year < 70) ? 2000 : 1900;
                    dp_phase = PH_SP;
                end
            end
            PH_ISOOPT: begin
                if (c == CH_SPACE) dp_phase = PH_ISOD1;
                else asc_day_lead(c);
            end
            PH_ISOD1: asc_day_lead(c);
            PH_ISOD2: begin
                if (c == CH_SPACE) begin
                    dp_phase = PH_HOUR;
                    dp_count = 0;
                end else if (is_digit(c)) begin
                    dp_day = dp_day * 10 + 32'(c - CH_ZERO);
                    dp_phase = PH_SP;
                end else begin
                    parse_error();
                end
            end
            PH_SP: begin
                if (c != CH_SPACE) begin
                    parse_error();
                end else begin
                    dp_phase = PH_HOUR;
                    dp_count = 0;
                end
            end
            PH_HOUR: if (take_digit(c, dp_hour, 2)) dp_phase = PH_COLON1;
            PH_COLON1: begin
                if (c != CH_COLON) parse_error();
                else dp_phase = PH_MIN;
            end
            PH_MIN: if (take_digit(c, dp_minute, 2)) dp_phase = PH_COLON2;
            PH_COLON2: begin
                if (c != CH_COLON) parse_error();
                else dp_phase = PH_SEC;
            end
            PH_SEC: begin
                if (take_digit(c, dp_second, 2))
                    dp_phase = (dp_fmt == FMT_ASC) ? PH_SP2 : PH_DONE;
            end
            PH_SP2: begin
                if (c != CH_SPACE) begin
                    parse_error();
                end else begin
                    dp_phase = PH_YEAR4;
                    dp_count = 0;
                end
            end
            default: ;
        endcase
    endfunction

    // Checks the parsed fields and turns them into seconds since 1970, modulo 2^32.
    function automatic bit date_seconds(output logic [31:0] secs);
        logic [63:0] y, d, t;
        int          mm;
        y = 64'(dp_year);
        d = 64'(dp_day);
        if (dp_phase != PH_DONE || dp_error) return 1'b0;
        if (dp_hour > 23 || dp_minute > 59 || dp_second > 59) return 1'b0;
        if (dp_month >= MONTHS) return 1'b0;
        if (d == 29 && dp_month == M_FEB) begin
            if (y[1:0] != 2'b00 || (y % 100 == 0 && y % 400 != 0)) return 1'b0;
        end else if (d > 64'(days_in_month[dp_month])) begin
            return 1'b0;
        end
        // Years start in March so that the leap day falls at the end.
        mm = int'(dp_month) - 1;
        if (mm <= 0) begin
            mm += 12;
            y = (y - 64'd1) & 64'hFFFF_FFFF;
        end
        t = 64'd365 * y + y / 64'd4 - y / 64'd100 + y / 64'd400
            + 64'((367 * mm) / 12) - 64'd30 + d - 64'd1 - 64'd719527 + 64'd31 + 64'd28;
        t = (t & 64'hFFFF_FFFF) * 64'd86400 + 64'(dp_hour) * 64'd3600
            + 64'(dp_minute) * 64'd60 + 64'(dp_second);
        secs = t[31:0];
        return 1'b1;
    endfunction

    // Advances the prediction by one byte; returns 1 when the byte ends a string.
    function automatic bit predict_byte(input t_item it, output t_result res);
        logic [31:0] secs;
        feed_byte(it.char_byte);
        res = '0;
        if (!it.last_byte) return 1'b0;
        if (date_seconds(secs)) begin
            res.date_valid = 1'b1;
            res.unix_seconds = secs;
        end
        parser_clear();
        return 1'b1;
    endfunction

    function automatic bit calm_window();
        return (cycle_no % 1600) >= 1200;
    endfunction

    function automatic int unsigned pick_pause(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Sender: one item offered per cycle unless the block stalls, with random gaps and an optional drain pause.
    always @(posedge clk) begin : byte_driver
        t_feed_byte head;
        logic       nxt_valid;
        t_item      nxt_item;
        t_result    outcome;
        cycle_no++;
        if (!rst_n) begin
            parser_clear();
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            nxt_item = in_item;
            if (in_valid && in_stall) in_stalls++;
            if (in_valid && !in_stall) begin
                bytes_taken++;
                if (predict_byte(in_item, outcome)) begin
                    expected_dates.push_back(outcome);
                    strings_done++;
                    if (outcome.date_valid) strings_valid++;
                end
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (byte_feed.size() != 0 &&
                             !(byte_feed[0].drain_first && expected_dates.size() != 0)) begin
                    head = byte_feed.pop_front();
                    nxt_item = head.item;
                    nxt_valid = 1'b1;
                    // No gaps while the receiver holds off, so the block fills up.
                    gap_left = (hold_left != 0) ? 0 : pick_pause(calm_window());
                end
            end
            in_valid <= nxt_valid;
            in_item <= nxt_item;
        end
    end

    // Receiver: checks each result and stalls at random, once for a long stretch.
    always @(posedge clk) begin : result_monitor
        t_result want;
        logic    nxt_stall;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_dates.size() == 0) begin
                    report_error($sformatf("result with no string pending: valid=%0b secs=%0d",
                                           out_item.date_valid, out_item.unix_seconds));
                end else begin
                    want = expected_dates.pop_front();
                    if (out_item.date_valid !== want.date_valid ||
                        out_item.unix_seconds !== want.unix_seconds)
                        report_error($sformatf(
                            "string %0d: expected valid=%0b secs=%0d, got valid=%0b secs=%0d",
                            results_checked, want.date_valid, want.unix_seconds,
                            out_item.date_valid, out_item.unix_seconds));
                    results_checked++;
                end
            end
            if (!hold_started && bytes_taken >= 150) begin
                hold_started = 1'b1;
                hold_left = 1000;
            end
            if (hold_left != 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else begin
                stall_left = pick_pause(calm_window());
                nxt_stall = 1'b0;
            end
            out_stall <= nxt_stall;
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
    endtask

    task automatic commit_string(input bit drain_first);
        t_feed_byte fb;
        foreach (str_bytes[i]) begin
            fb.item.char_byte = str_bytes[i];
            fb.item.last_byte = (i == str_bytes.size() - 1);
            fb.drain_first = drain_first && (i == 0);
            byte_feed.push_back(fb);
        end
        str_bytes.delete();
    endtask

    task automatic add_directed(input string s);
        add_text(s);
        commit_string(1'b0);
    endtask

    function automatic int unsigned pick_field(input int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, top);
        if (r < 95) return top + $urandom_range(0, 1);
        return $urandom_range(0, 99);
    endfunction

    function automatic int unsigned pick_year();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1900, 2100);
        if (r < 85) return $urandom_range(0, 9999);
        if (r < 92) return ($urandom_range(0, 1) != 0) ? 9999 : 0;
        return $urandom_range(0, 24) * 100;
    endfunction

    function automatic string pick_month();
        string names, leads;
        int unsigned r, m;
        names = "JanFebMarAprMayJunJulAugSepOctNovDec";
        leads = "JFMASOND";
        r = $urandom_range(0, 99);
        m = $urandom_range(0, 11);
        if (r < 85) return names.substr(3 * m, 3 * m + 2);
        if (r < 95)
            return $sformatf("%c%c%c", leads[$urandom_range(0, 7)],
                             $urandom_range(97, 122), $urandom_range(97, 122));
        return $sformatf("%c%c%c", $urandom_range(65, 90),
                         $urandom_range(97, 122), $urandom_range(97, 122));
    endfunction

    // Weekday token: mostly letters, sometimes any byte that does not end the token.
    task automatic add_token();
        int unsigned n;
        logic [7:0]  b;
        n = $urandom_range(0, 9);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_SPACE || b == CH_COMMA) b = "x";
            end else begin
                b = 8'($urandom_range(65, 122));
            end
            str_bytes.push_back(b);
        end
    endtask

    task automatic add_random_string(input bit drain_first);
        int unsigned kind, day, hh, mi, ss, n, idx;
        string       mon, clock_text;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            n = $urandom_range(1, 12);
            repeat (n) str_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            mon = pick_month();
            day = pick_field(31);
            hh = pick_field(23);
            mi = pick_field(59);
            ss = pick_field(59);
            clock_text = $sformatf("%02d:%02d:%02d", hh, mi, ss);
            add_token();
            if (kind < 45) begin
                add_text($sformatf("%s%02d %s %04d %s",
                                   ($urandom_range(0, 3) == 0) ? "," : ", ",
                                   day, mon, pick_year(), clock_text));
            end else if (kind < 70) begin
                add_text($sformatf(", %02d-%s-%02d %s", day, mon,
                                   $urandom_range(0, 99), clock_text));
            end else begin
                add_text({" ", mon});
                str_bytes.push_back(($urandom_range(0, 9) == 0) ?
                                    8'($urandom_range(33, 126)) : CH_SPACE);
                if (day < 10 && $urandom_range(0, 2) == 0) add_text($sformatf(" %0d", day));
                else if (day < 10 && $urandom_range(0, 1) == 0) add_text($sformatf("%0d", day));
                else add_text($sformatf("%02d", day));
                add_text($sformatf(" %s %04d", clock_text, pick_year()));
            end
            n = $urandom_range(0, 99);
            if (n < 50) begin
                add_text(" GMT");
            end else if (n >= 70) begin
                repeat ($urandom_range(1, 4)) str_bytes.push_back(8'($urandom_range(0, 255)));
            end
            // Some strings get a damaged byte or are cut short.
            n = $urandom_range(0, 99);
            if (n < 12) begin
                idx = $urandom_range(0, str_bytes.size() - 1);
                str_bytes[idx] = 8'($urandom_range(0, 255));
            end else if (n < 20) begin
                idx = $urandom_range(1, str_bytes.size());
                while (str_bytes.size() > idx) void'(str_bytes.pop_back());
            end
        end
        commit_string(drain_first);
    endtask

    initial begin : stimulus
        int unsigned strings_queued;
        add_directed("Sun, 06 Nov 1994 08:49:37 GMT");
        add_directed("Sunday, 06-Nov-94 08:49:37 GMT");
        add_directed("Sun Nov  6 08:49:37 1994");
        add_directed(",31-Dec-69 23:59:59");
        add_directed(",01-Jan-70 00:00:00");
        add_directed(",29 Feb 2000 23:59:59");
        add_directed(",29 Feb 1900 00:00:00");
        add_directed(",29 Feb 2023 00:00:00");
        add_directed(",00 Jan 2020 00:00:00");
        add_directed(",01 Jan 0000 00:00:00");
        add_directed(",31 Dec 9999 23:59:59");
        add_directed(",01 Jan 2001 24:00:00");
        add_directed(",31 Apr 2020 00:00:00");
        add_directed(",0x Nov 1994 08:49:37");
        add_directed(",06 Nov 19");
        add_directed("Wed Aqq 31 23:59:59 1969");
        add_directed("Wed Dec-31 23:59:59 1969");
        add_directed(",");
        str_bytes.push_back(8'hFF);
        commit_string(1'b0);

        strings_queued = 0;
        while (byte_feed.size() < 550) begin
            // Once the sender waits for every result before going on.
            add_random_string(strings_queued == 2);
            strings_queued++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_feed.size() != 0 || in_valid) @(posedge clk);
        while (expected_dates.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Parsed %0d date strings (%0d valid) from %0d bytes in all three layouts.",
                 strings_done, strings_valid, bytes_taken);
        $display("The input was held back on %0d cycles; %0d results were compared.",
                 in_stalls, results_checked);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches in total.", errors);
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("Timeout with %0d results outstanding.", expected_dates.size());
        $display("Verification failed");
        $finish;
    end

endmodule
